// File: rtl/cfta_pkg.sv
`timescale 1ns / 1ps

package cfta_pkg;

	// Fixed widths of the transaction fields
	localparam int unsigned FlowIdW   = 32;
	localparam int unsigned IpW       = 32;
	localparam int unsigned PortW     = 16;
	localparam int unsigned SecW      = 32;
	localparam int unsigned PnumW     = 64;
	localparam int unsigned StartW    = 32;
	localparam int unsigned TimeoutW  = 16;
	localparam int unsigned SlotW     = 6;
	localparam int unsigned StatusW   = 3;
	localparam int unsigned RemovedW  = 7;
	localparam int unsigned OpcodeW   = 2;
	localparam int unsigned CfgIndexW = 1;
	localparam int unsigned CfgDataW  = 32;

	// Opcodes of an input transaction
	localparam logic [OpcodeW-1:0] OP_RECV  = 2'd0;
	localparam logic [OpcodeW-1:0] OP_SEND  = 2'd1;
	localparam logic [OpcodeW-1:0] OP_SWEEP = 2'd2;
	localparam logic [OpcodeW-1:0] OP_TICK  = 2'd3;

	// Result status codes
	localparam logic [StatusW-1:0] ST_REFRESH = 3'd0;
	localparam logic [StatusW-1:0] ST_NEW     = 3'd1;
	localparam logic [StatusW-1:0] ST_FULL    = 3'd2;
	localparam logic [StatusW-1:0] ST_SEND    = 3'd3;
	localparam logic [StatusW-1:0] ST_SWEEP   = 3'd4;

	// Configuration register indexes
	localparam logic [CfgIndexW-1:0] CFG_IDLE_TIMEOUT = 1'd0;
	localparam logic [CfgIndexW-1:0] CFG_OUT_START    = 1'd1;

	// Register reset values
	localparam logic [TimeoutW-1:0] IDLE_TIMEOUT_RST = 16'd300;
	localparam logic [StartW-1:0]   OUT_START_RST    = 32'd2000;

	// Payload of one flow entry
	typedef struct packed {
		logic [FlowIdW-1:0] flow_id;
		logic [IpW-1:0]     ip;
		logic [PortW-1:0]   port;
		logic [SecW-1:0]    last_seen;
		logic [PnumW-1:0]   out_number;
	} flow_data_t;

	typedef struct packed {
		logic       valid;
		flow_data_t data;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_APPLY,
		S_SEND,
		S_SWEEP,
		S_REPORT
	} ctrl_state_t;

endpackage

// File: rtl/cfta_cell.sv
`timescale 1ns / 1ps

module cfta_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  cfta_pkg::entry_t d,
	output cfta_pkg::entry_t q
);
	import cfta_pkg::*;

	logic       valid_q;
	flow_data_t data_q;

	// Take the neighbor's valid bit on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	// Take the neighbor's payload on a shift
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d.data;
		end
	end

	assign q = {valid_q, data_q};

endmodule

// File: rtl/client_flow_table_with_aging.sv
`timescale 1ns / 1ps

// Flow table with idle aging, built as a ring of entry cells.
// Input channel (in_valid / in_stall) takes one opcode transaction at a time:
// receive, send fan-out, idle sweep or one-second tick. in_stall is high while
// a transaction is being worked on, including while its final result waits
// for room in the output register.
// Output channel (out_valid / out_stall) carries one result per receive or
// sweep, one per active entry for a send and none for a tick; last marks the
// final result.
// The table rotates one cell per cycle past a single processing head during a
// walk, unless an output stall holds a send; each walk covers all entries:
//   tick:    no result
//   receive: search walk and update walk, then the result is loaded; a full
//            table skips the update walk
//   sweep:   one walk, then the result with the freed count is loaded
//   send:    one walk, one result per active entry on the way
// One transaction runs at a time. A stall on the output freezes the ring when
// the head needs to emit; a pending result is held unchanged.
// Reset clears every entry's valid bit, the seconds clock and the output valid
// bit, and loads idle_timeout = 300 and outgoing_start = 2000.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module client_flow_table_with_aging #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic                               cfg_we,
	input  logic [cfta_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [cfta_pkg::CfgDataW-1:0]      cfg_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cfta_pkg::OpcodeW-1:0]       opcode,
	input  logic signed [cfta_pkg::FlowIdW-1:0] flow_id,
	input  logic [cfta_pkg::IpW-1:0]           peer_ip,
	input  logic [cfta_pkg::PortW-1:0]         peer_port,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cfta_pkg::StatusW-1:0]       status,
	output logic [cfta_pkg::SlotW-1:0]         slot,
	output logic signed [cfta_pkg::FlowIdW-1:0] flow_id_out,
	output logic [cfta_pkg::IpW-1:0]           peer_ip_out,
	output logic [cfta_pkg::PortW-1:0]         peer_port_out,
	output logic [cfta_pkg::PnumW-1:0]         packet_number,
	output logic [cfta_pkg::RemovedW-1:0]      removed_count,
	output logic                               last
);
	import cfta_pkg::*;

	localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

	// Ring of cells
	entry_t ring [TABLE_ENTRIES];
	entry_t head;
	entry_t wb;
	logic   advance;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			entry_t cell_d;
			if (gi == TABLE_ENTRIES - 1) begin : g_tail
				assign cell_d = wb;
			end else begin : g_mid
				assign cell_d = ring[gi + 1];
			end
			cfta_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (advance),
				.d      (cell_d),
				.q      (ring[gi])
			);
		end
	endgenerate

	assign head = ring[0];

	// Control and configuration state
	ctrl_state_t          state_q, state_d;
	logic [IdxW-1:0]      step_q;
	logic                 hit_q, free_q;
	logic [IdxW-1:0]      hit_idx_q, free_idx_q;
	logic [CntW-1:0]      count_q, sent_q, removed_q;
	logic [SecW-1:0]      now_q;
	logic [TimeoutW-1:0]  timeout_q;
	logic [StartW-1:0]    out_start_q;
	logic [StatusW-1:0]   rep_status_q;

	// Latched input transaction
	logic [OpcodeW-1:0]   op_q;
	logic [FlowIdW-1:0]   fid_q;
	logic [IpW-1:0]       ip_q;
	logic [PortW-1:0]     port_q;

	// Output register
	logic                 out_valid_q;
	logic [StatusW-1:0]   status_q;
	logic [SlotW-1:0]     slot_q;
	logic [FlowIdW-1:0]   fid_out_q;
	logic [IpW-1:0]       ip_out_q;
	logic [PortW-1:0]     port_out_q;
	logic [PnumW-1:0]     pnum_q;
	logic [RemovedW-1:0]  removed_out_q;
	logic                 last_q;

	// Head evaluation
	logic            accept;
	logic            last_step;
	logic            out_free;
	logic            head_match, head_free;
	logic            hit_now, free_now;
	logic [IdxW-1:0] target;
	logic [SecW-1:0] idle_age;
	logic            expired;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign last_step  = (step_q == LastIdx);
	assign out_free   = !out_valid_q || !out_stall;
	assign head_match = head.valid && (head.data.ip == ip_q) && (head.data.port == port_q);
	assign head_free  = !head.valid;
	assign hit_now    = hit_q || head_match;
	assign free_now   = free_q || head_free;
	assign target     = hit_q ? hit_idx_q : free_idx_q;
	assign idle_age   = now_q - head.data.last_seen;
	assign expired    = head.valid && (idle_age > SecW'(timeout_q));

	// Output transaction built this cycle
	logic                 load_out;
	logic [StatusW-1:0]   o_status;
	logic [SlotW-1:0]     o_slot;
	logic [FlowIdW-1:0]   o_fid;
	logic [IpW-1:0]       o_ip;
	logic [PortW-1:0]     o_port;
	logic [PnumW-1:0]     o_pnum;
	logic [RemovedW-1:0]  o_removed;
	logic                 o_last;
	logic                 o_show;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (opcode)
						OP_RECV:  state_d = S_SEARCH;
						OP_SEND:  state_d = S_SEND;
						OP_SWEEP: state_d = S_SWEEP;
						OP_TICK:  state_d = S_IDLE;
					endcase
				end
			end
			S_SEARCH: begin
				if (last_step) begin
					state_d = (hit_now || free_now) ? S_APPLY : S_REPORT;
				end
			end
			S_APPLY: begin
				if (last_step) begin
					state_d = S_REPORT;
				end
			end
			S_SEND: begin
				if (advance && last_step) begin
					state_d = S_IDLE;
				end
			end
			S_SWEEP: begin
				if (last_step) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Ring control, write-back and result fields
	always_comb begin
		advance   = 1'b0;
		wb        = head;
		load_out  = 1'b0;
		o_status  = rep_status_q;
		o_slot    = '0;
		o_fid     = '0;
		o_ip      = '0;
		o_port    = '0;
		o_pnum    = '0;
		o_removed = '0;
		o_last    = 1'b1;
		o_show    = (rep_status_q == ST_REFRESH) || (rep_status_q == ST_NEW);
		unique case (state_q)
			S_IDLE: begin
			end
			S_SEARCH: begin
				advance = 1'b1;
			end
			S_APPLY: begin
				advance = 1'b1;
				if (step_q == target) begin
					wb.valid               = 1'b1;
					wb.data.flow_id        = fid_q;
					wb.data.last_seen      = now_q;
					if (!hit_q) begin
						wb.data.ip         = ip_q;
						wb.data.port       = port_q;
						wb.data.out_number = PnumW'(out_start_q);
					end
				end
			end
			S_SEND: begin
				if (head.valid) begin
					if (out_free) begin
						advance            = 1'b1;
						load_out           = 1'b1;
						o_status           = ST_SEND;
						o_slot             = SlotW'(step_q);
						o_fid              = head.data.flow_id;
						o_ip               = head.data.ip;
						o_port             = head.data.port;
						o_pnum             = head.data.out_number;
						o_last             = (CntW'(sent_q + 1'b1) == count_q);
						wb.data.out_number = head.data.out_number + 1'b1;
					end
				end else begin
					advance = 1'b1;
				end
			end
			S_SWEEP: begin
				advance = 1'b1;
				if (expired) begin
					wb.valid = 1'b0;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (o_show) begin
						o_slot = SlotW'(target);
						o_fid  = fid_q;
						o_ip   = ip_q;
						o_port = port_q;
					end
					if (rep_status_q == ST_SWEEP) begin
						o_removed = RemovedW'(removed_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			count_q     <= '0;
			sent_q      <= '0;
			removed_q   <= '0;
			now_q       <= '0;
			timeout_q   <= IDLE_TIMEOUT_RST;
			out_start_q <= OUT_START_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Apply configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IDLE_TIMEOUT: timeout_q   <= cfg_data[TimeoutW-1:0];
					CFG_OUT_START:    out_start_q <= cfg_data[StartW-1:0];
				endcase
			end

			// Start a transaction
			if (accept) begin
				step_q    <= '0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				sent_q    <= '0;
				removed_q <= '0;
				if (opcode == OP_TICK) begin
					now_q <= now_q + 1'b1;
				end
			end

			// Advance the walk position
			if (advance) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end

			// Record search hits and the lowest free slot
			if (state_q == S_SEARCH) begin
				if (head_match) begin
					hit_q <= 1'b1;
				end
				if (head_free) begin
					free_q <= 1'b1;
				end
			end

			// Count a new registration
			if ((state_q == S_APPLY) && (step_q == target) && !hit_q) begin
				count_q <= count_q + 1'b1;
			end

			// Count emitted send results
			if ((state_q == S_SEND) && load_out) begin
				sent_q <= sent_q + 1'b1;
			end

			// Drop expired entries from the count
			if ((state_q == S_SWEEP) && expired) begin
				removed_q <= removed_q + 1'b1;
				count_q   <= count_q - 1'b1;
			end

			// Hold or release the output register
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			fid_q  <= flow_id;
			ip_q   <= peer_ip;
			port_q <= peer_port;
		end

		if (state_q == S_SEARCH) begin
			if (head_match && !hit_q) begin
				hit_idx_q <= step_q;
			end
			if (head_free && !free_q) begin
				free_idx_q <= step_q;
			end
			if (last_step) begin
				if (hit_now) begin
					rep_status_q <= ST_REFRESH;
				end else if (free_now) begin
					rep_status_q <= ST_NEW;
				end else begin
					rep_status_q <= ST_FULL;
				end
			end
		end

		if ((state_q == S_SWEEP) && (op_q == OP_SWEEP)) begin
			rep_status_q <= ST_SWEEP;
		end

		if (load_out) begin
			status_q      <= o_status;
			slot_q        <= o_slot;
			fid_out_q     <= o_fid;
			ip_out_q      <= o_ip;
			port_out_q    <= o_port;
			pnum_q        <= o_pnum;
			removed_out_q <= o_removed;
			last_q        <= o_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign flow_id_out   = fid_out_q;
	assign peer_ip_out   = ip_out_q;
	assign peer_port_out = port_out_q;
	assign packet_number = pnum_q;
	assign removed_count = removed_out_q;
	assign last          = last_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cfta_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int LATENCY = 2 * TABLE_ENTRIES + 8;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [StatusW-1:0]  status;
		logic [SlotW-1:0]    slot;
		logic [FlowIdW-1:0]  flow_id;
		logic [IpW-1:0]      ip;
		logic [PortW-1:0]    port;
		logic [PnumW-1:0]    pnum;
		logic [RemovedW-1:0] removed;
		logic                last;
	} flow_report_t;

	typedef struct {
		bit               used;
		bit [FlowIdW-1:0] flow_id;
		bit [IpW-1:0]     ip;
		bit [PortW-1:0]   port;
		bit [SecW-1:0]    seen;
		bit [PnumW-1:0]   pnum;
	} flow_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OpcodeW-1:0] opcode = '0;
	logic signed [FlowIdW-1:0] flow_id = '0;
	logic [IpW-1:0] peer_ip = '0;
	logic [PortW-1:0] peer_port = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [StatusW-1:0] status;
	logic [SlotW-1:0] slot;
	logic signed [FlowIdW-1:0] flow_id_out;
	logic [IpW-1:0] peer_ip_out;
	logic [PortW-1:0] peer_port_out;
	logic [PnumW-1:0] packet_number;
	logic [RemovedW-1:0] removed_count;
	logic last;

	// Shadow copy of the flow table and its registers
	flow_slot_t flows[TABLE_ENTRIES];
	bit [SecW-1:0] now_sec = '0;
	bit [TimeoutW-1:0] cur_timeout = IDLE_TIMEOUT_RST;
	bit [StartW-1:0] cur_start = OUT_START_RST;

	flow_report_t due_reports[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	client_flow_table_with_aging #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.flow_id(flow_id),
		.peer_ip(peer_ip),
		.peer_port(peer_port),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot(slot),
		.flow_id_out(flow_id_out),
		.peer_ip_out(peer_ip_out),
		.peer_port_out(peer_port_out),
		.packet_number(packet_number),
		.removed_count(removed_count),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 200)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Build one report from a table slot
	function automatic flow_report_t slot_report(input logic [StatusW-1:0] st, input int idx,
			input logic [PnumW-1:0] pnum, input logic isLast);
		flow_report_t r;
		r.status = st;
		r.slot = idx[SlotW-1:0];
		r.flow_id = flows[idx].flow_id;
		r.ip = flows[idx].ip;
		r.port = flows[idx].port;
		r.pnum = pnum;
		r.removed = '0;
		r.last = isLast;
		return r;
	endfunction

	// Advance the shadow table by one transaction and queue its reports
	task automatic apply_flow_op(input logic [OpcodeW-1:0] op, input logic [FlowIdW-1:0] fid,
			input logic [IpW-1:0] ip, input logic [PortW-1:0] port);
		flow_report_t r;
		int hit;
		int active;
		int k;
		int freed;
		hit = -1;
		active = 0;
		k = 0;
		freed = 0;
		case (op)
			OP_RECV: begin
				for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
					if (flows[i].used && flows[i].ip == ip && flows[i].port == port)
						hit = i;
				if (hit >= 0) begin
					flows[hit].flow_id = fid;
					flows[hit].seen = now_sec;
					due_reports.push_back(slot_report(ST_REFRESH, hit, '0, 1'b1));
				end else begin
					for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
						if (!flows[i].used)
							hit = i;
					if (hit >= 0) begin
						flows[hit].used = 1'b1;
						flows[hit].flow_id = fid;
						flows[hit].ip = ip;
						flows[hit].port = port;
						flows[hit].seen = now_sec;
						flows[hit].pnum = {32'd0, cur_start};
						due_reports.push_back(slot_report(ST_NEW, hit, '0, 1'b1));
					end else begin
						r = '0;
						r.status = ST_FULL;
						r.last = 1'b1;
						due_reports.push_back(r);
					end
				end
			end
			OP_SEND: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (flows[i].used)
						active++;
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (flows[i].used) begin
						k++;
						due_reports.push_back(slot_report(ST_SEND, i, flows[i].pnum, k == active));
						flows[i].pnum = flows[i].pnum + 64'd1;
					end
			end
			OP_SWEEP: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (flows[i].used && (now_sec - flows[i].seen) > {16'd0, cur_timeout}) begin
						flows[i].used = 1'b0;
						freed++;
					end
				r = '0;
				r.status = ST_SWEEP;
				r.removed = freed[RemovedW-1:0];
				r.last = 1'b1;
				due_reports.push_back(r);
			end
			default: now_sec = now_sec + 32'd1;
		endcase
	endtask

	// Offer one transaction, idling at random first, and predict it once taken
	task automatic send_item(input logic [OpcodeW-1:0] op, input logic [FlowIdW-1:0] fid,
			input logic [IpW-1:0] ip, input logic [PortW-1:0] port);
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		flow_id <= fid;
		peer_ip <= ip;
		peer_port <= port;
		do
			@(posedge clk);
		while (in_stall);
		apply_flow_op(op, fid, ip, port);
	endtask

	// Hold the input until every report is in, then let the block settle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic set_regs(input logic [TimeoutW-1:0] timeout, input logic [StartW-1:0] start);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDLE_TIMEOUT;
		cfg_data <= {16'($urandom), timeout};
		@(posedge clk);
		cfg_index <= CFG_OUT_START;
		cfg_data <= start;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_timeout = timeout;
		cur_start = start;
	endtask

	task automatic test_basic_ops();
		// empty table: send gives nothing, sweep frees nothing
		send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
		send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
		// register field extremes, then refresh with same and new stream IDs
		send_item(OP_RECV, 32'h8000_0000, 32'h0000_0000, 16'h0000);
		send_item(OP_RECV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_RECV, 32'h8000_0000, 32'h0000_0000, 16'h0000);
		send_item(OP_RECV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
		send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
		send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
		send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
		// zero timeout and a start that carries past 32 bits
		drain_block();
		set_regs(16'd0, 32'hFFFF_FFFF);
		send_item(OP_RECV, 32'h0000_0001, 32'hC0A8_0001, 16'd443);
		send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
		send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
		send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
		send_item(OP_RECV, 32'h0000_0002, 32'h0A00_0002, 16'd5000);
		send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
		send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
	endtask

	task automatic test_full_table();
		logic [IpW-1:0] ip;
		logic [IpW-1:0] keep_ip;
		logic [PortW-1:0] keep_port;
		drain_block();
		set_regs(16'hFFFF, 32'd0);
		// fill every slot with distinct keys
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			ip = $urandom;
			ip[31:26] = i[5:0];
			if (i == 7) begin
				keep_ip = ip;
				keep_port = 16'($urandom);
				send_item(OP_RECV, $urandom, keep_ip, keep_port);
			end else
				send_item(OP_RECV, $urandom, ip, 16'($urandom));
		end
		send_item(OP_RECV, $urandom, $urandom, 16'($urandom));
		send_item(OP_RECV, $urandom, keep_ip, keep_port);
		send_item(OP_RECV, $urandom, $urandom, 16'($urandom));
		send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
		send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
		send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
		// short timeout then frees the whole table at once
		drain_block();
		set_regs(16'd1, $urandom);
		send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
		send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
		send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
	endtask

	task automatic test_random_traffic();
		logic [IpW-1:0] pool_ip[16];
		logic [PortW-1:0] pool_port[16];
		logic [FlowIdW-1:0] pool_fid[16];
		logic [FlowIdW-1:0] fid;
		int pick;
		int r;
		for (int phase = 0; phase < 6; phase++) begin
			drain_block();
			if (phase == 2)
				set_regs(16'hFFFF, 32'hFFFF_FFFE);
			else if ($urandom_range(3) == 0)
				set_regs(16'($urandom), $urandom);
			else
				set_regs(16'($urandom_range(1, 6)), $urandom);
			for (int k = 0; k < 16; k++) begin
				pool_ip[k] = $urandom;
				pool_port[k] = 16'($urandom);
				pool_fid[k] = $urandom;
			end
			calm = (phase == 1);
			repeat (45) begin
				r = $urandom_range(99);
				if (r < 45) begin
					// mostly known clients, same or new stream ID
					if ($urandom_range(9) < 8) begin
						pick = $urandom_range(15);
						fid = ($urandom_range(1) == 0) ? pool_fid[pick] : $urandom;
						pool_fid[pick] = fid;
						send_item(OP_RECV, fid, pool_ip[pick], pool_port[pick]);
					end else
						send_item(OP_RECV, $urandom, $urandom, 16'($urandom));
				end else if (r < 58)
					send_item(OP_SEND, $urandom, $urandom, 16'($urandom));
				else if (r < 70)
					send_item(OP_SWEEP, $urandom, $urandom, 16'($urandom));
				else
					send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	// Stall the result side at random
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 11);

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin
		flow_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0)
				report_mismatch("unexpected result status", 64'(status), 64'd0);
			else begin
				want = due_reports.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (slot !== want.slot)
					report_mismatch("slot", 64'(slot), 64'(want.slot));
				if (flow_id_out !== want.flow_id)
					report_mismatch("flow_id_out", 64'(flow_id_out), 64'(want.flow_id));
				if (peer_ip_out !== want.ip)
					report_mismatch("peer_ip_out", 64'(peer_ip_out), 64'(want.ip));
				if (peer_port_out !== want.port)
					report_mismatch("peer_port_out", 64'(peer_port_out), 64'(want.port));
				if (packet_number !== want.pnum)
					report_mismatch("packet_number", packet_number, want.pnum);
				if (removed_count !== want.removed)
					report_mismatch("removed_count", 64'(removed_count), 64'(want.removed));
				if (last !== want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_full_table();
		test_random_traffic();
		drain_block();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: client_flow_table_with_aging.f
rtl/cfta_pkg.sv
rtl/cfta_cell.sv
rtl/client_flow_table_with_aging.sv
bench/testbench.sv
